// File: design/ramr_pkg.sv
package ramr_pkg;

    // operation codes
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    // result field widths
    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 32;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } t_state;

endpackage

// File: design/ramr_serdiv.sv
module ramr_serdiv #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_dvs;

    logic [WIDTH:0]   w_rem_sh;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;

    // shift in the next dividend bit and trial-subtract the divisor
    assign w_rem_sh = {r_rem, r_q[WIDTH-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // remainder and quotient shift registers, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[WIDTH-1:0] : w_rem_sh[WIDTH-1:0];
            r_q   <= {r_q[WIDTH-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dvs))
        else $error("partial remainder reached the divisor");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divide started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done pulse without a running divide");

endmodule

// File: design/rational_add_mul_reduce_core.sv
// Adds (opcode 0) or multiplies (opcode 1) two fractions of OPERAND_WIDTH-bit signed
// parts and returns the result in lowest terms, signs as the products give them (the
// denominator is not made positive). A zero input denominator returns 0/0 with
// o_div_zero set; a zero numerator returns 0/1. One request is worked at a time:
// the products come from a shift-add multiplier, then the terms are combined, then
// a binary GCD reduces them by shifts and subtracts, then two restoring divisions
// run in one shared serial divider, and then the result is handed off. A zero
// denominator goes straight to the hand-off, and a zero numerator skips the GCD and
// the divisions. A finished result waits in the output register while the next
// request is taken, and a stalled output holds the following result in the
// hand-off state until the register frees. Results wider than 33/32 bits wrap.
module rational_add_mul_reduce_core #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_opcode,
    input  logic signed [OPERAND_WIDTH-1:0]         i_num_a,
    input  logic signed [OPERAND_WIDTH-1:0]         i_den_a,
    input  logic signed [OPERAND_WIDTH-1:0]         i_num_b,
    input  logic signed [OPERAND_WIDTH-1:0]         i_den_b,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [ramr_pkg::NUM_OUT_W-1:0]   o_res_num,
    output logic signed [ramr_pkg::DEN_OUT_W-1:0]   o_res_den,
    output logic                                    o_div_zero
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int CW = $clog2(W);
    localparam int XN = (PW + 1 > ramr_pkg::NUM_OUT_W) ? PW + 1 : ramr_pkg::NUM_OUT_W;
    localparam int XD = (PW + 1 > ramr_pkg::DEN_OUT_W) ? PW + 1 : ramr_pkg::DEN_OUT_W;

    ramr_pkg::t_state r_state, n_state;

    // multiplier lanes: numerator terms and denominator product
    logic [PW-1:0] r_ma0, r_ma1, r_ma2;
    logic [W-1:0]  r_mb0, r_mb1, r_mb2;
    logic [PW-1:0] r_p0, r_p1, r_p2;
    logic [CW-1:0] r_cnt;
    logic          r_mul;
    logic          r_s0, r_s1, r_sd, r_sn;

    // gcd and quotient registers
    logic [PW-1:0] r_u, r_v;
    logic [PW-1:0] r_qn, r_qd;
    logic [PW-1:0] r_qn_res;

    // staged result
    logic [ramr_pkg::NUM_OUT_W-1:0] r_fin_num;
    logic [ramr_pkg::DEN_OUT_W-1:0] r_fin_den;
    logic                           r_fin_dz;

    // output register
    logic                           r_out_valid;
    logic [ramr_pkg::NUM_OUT_W-1:0] r_out_num;
    logic [ramr_pkg::DEN_OUT_W-1:0] r_out_den;
    logic                           r_out_dz;

    logic [W-1:0]         w_mag_na, w_mag_da, w_mag_nb, w_mag_db;
    logic                 w_in_acc, w_den_zero, w_out_free, w_is_mul;
    logic signed [PW:0]   w_t0, w_t1, w_n;
    logic [PW-1:0]        w_n_mag;
    logic                 w_v_zero, w_u_gt;
    logic                 w_div_start, w_div_done;
    logic [PW-1:0]        w_div_dividend, w_div_quot;
    logic signed [PW:0]   w_sq_num, w_sq_den;
    logic signed [XN-1:0] w_num_ext;
    logic signed [XD-1:0] w_den_ext;

    // operand magnitudes
    assign w_mag_na = i_num_a[W-1] ? W'(-i_num_a) : i_num_a;
    assign w_mag_da = i_den_a[W-1] ? W'(-i_den_a) : i_den_a;
    assign w_mag_nb = i_num_b[W-1] ? W'(-i_num_b) : i_num_b;
    assign w_mag_db = i_den_b[W-1] ? W'(-i_den_b) : i_den_b;

    assign w_in_acc   = i_in_valid && (r_state == ramr_pkg::S_IDLE);
    assign w_den_zero = (i_den_a == '0) || (i_den_b == '0);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_is_mul   = (i_opcode == ramr_pkg::OP_MUL);

    // combine signed terms into the unreduced numerator
    assign w_t0    = r_s0 ? -$signed({1'b0, r_p0}) : $signed({1'b0, r_p0});
    assign w_t1    = r_s1 ? -$signed({1'b0, r_p1}) : $signed({1'b0, r_p1});
    assign w_n     = r_mul ? w_t0 : w_t0 + w_t1;
    assign w_n_mag = w_n[PW] ? PW'(-w_n) : w_n[PW-1:0];

    assign w_v_zero = (r_v == '0);
    assign w_u_gt   = (r_u > r_v);

    // apply signs to the quotients and wrap to the result widths
    assign w_sq_num  = r_sn ? -$signed({1'b0, r_qn_res}) : $signed({1'b0, r_qn_res});
    assign w_sq_den  = r_sd ? -$signed({1'b0, w_div_quot}) : $signed({1'b0, w_div_quot});
    assign w_num_ext = XN'(w_sq_num);
    assign w_den_ext = XD'(w_sq_den);

    // shared serial divider
    ramr_serdiv #(
        .WIDTH (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_u),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ramr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and divider control
    always_comb begin
        n_state        = r_state;
        w_div_start    = 1'b0;
        w_div_dividend = r_qn;
        unique case (r_state)
            ramr_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_den_zero ? ramr_pkg::S_DONE : ramr_pkg::S_MUL;
                end
            end
            ramr_pkg::S_MUL: begin
                if (r_cnt == CW'(W - 1)) begin
                    n_state = ramr_pkg::S_SUM;
                end
            end
            ramr_pkg::S_SUM: begin
                n_state = (w_n == '0) ? ramr_pkg::S_DONE : ramr_pkg::S_GCD;
            end
            ramr_pkg::S_GCD: begin
                if (w_v_zero) begin
                    w_div_start = 1'b1;
                    n_state     = ramr_pkg::S_DIVN;
                end
            end
            ramr_pkg::S_DIVN: begin
                if (w_div_done) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = r_qd;
                    n_state        = ramr_pkg::S_DIVD;
                end
            end
            ramr_pkg::S_DIVD: begin
                if (w_div_done) begin
                    n_state = ramr_pkg::S_DONE;
                end
            end
            ramr_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = ramr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ramr_pkg::S_IDLE;
            end
        endcase
    end

    // datapath: multiply, combine, reduce, divide
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ramr_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_mul <= w_is_mul;
                    r_ma0 <= PW'(w_mag_na);
                    r_mb0 <= w_is_mul ? w_mag_nb : w_mag_db;
                    r_ma1 <= PW'(w_mag_nb);
                    r_mb1 <= w_mag_da;
                    r_ma2 <= PW'(w_mag_da);
                    r_mb2 <= w_mag_db;
                    r_p0  <= '0;
                    r_p1  <= '0;
                    r_p2  <= '0;
                    r_cnt <= '0;
                    r_s0  <= i_num_a[W-1] ^ (w_is_mul ? i_num_b[W-1] : i_den_b[W-1]);
                    r_s1  <= i_num_b[W-1] ^ i_den_a[W-1];
                    r_sd  <= i_den_a[W-1] ^ i_den_b[W-1];
                    if (w_den_zero) begin
                        r_fin_num <= '0;
                        r_fin_den <= '0;
                        r_fin_dz  <= 1'b1;
                    end
                end
            end
            ramr_pkg::S_MUL: begin
                if (r_mb0[0]) r_p0 <= r_p0 + r_ma0;
                if (r_mb1[0]) r_p1 <= r_p1 + r_ma1;
                if (r_mb2[0]) r_p2 <= r_p2 + r_ma2;
                r_ma0 <= {r_ma0[PW-2:0], 1'b0};
                r_ma1 <= {r_ma1[PW-2:0], 1'b0};
                r_ma2 <= {r_ma2[PW-2:0], 1'b0};
                r_mb0 <= {1'b0, r_mb0[W-1:1]};
                r_mb1 <= {1'b0, r_mb1[W-1:1]};
                r_mb2 <= {1'b0, r_mb2[W-1:1]};
                r_cnt <= r_cnt + 1'b1;
            end
            ramr_pkg::S_SUM: begin
                r_sn <= w_n[PW];
                r_u  <= w_n_mag;
                r_qn <= w_n_mag;
                r_v  <= r_p2;
                r_qd <= r_p2;
                if (w_n == '0) begin
                    r_fin_num <= '0;
                    r_fin_den <= ramr_pkg::DEN_OUT_W'(1);
                    r_fin_dz  <= 1'b0;
                end
            end
            ramr_pkg::S_GCD: begin
                // binary gcd; common factors of two come off the dividends too
                if (!w_v_zero) begin
                    if (!r_u[0] && !r_v[0]) begin
                        r_u  <= {1'b0, r_u[PW-1:1]};
                        r_v  <= {1'b0, r_v[PW-1:1]};
                        r_qn <= {1'b0, r_qn[PW-1:1]};
                        r_qd <= {1'b0, r_qd[PW-1:1]};
                    end else if (!r_u[0]) begin
                        r_u <= {1'b0, r_u[PW-1:1]};
                    end else if (!r_v[0]) begin
                        r_v <= {1'b0, r_v[PW-1:1]};
                    end else if (w_u_gt) begin
                        r_u <= r_v;
                        r_v <= r_u - r_v;
                    end else begin
                        r_v <= r_v - r_u;
                    end
                end
            end
            ramr_pkg::S_DIVN: begin
                if (w_div_done) begin
                    r_qn_res <= w_div_quot;
                end
            end
            ramr_pkg::S_DIVD: begin
                if (w_div_done) begin
                    r_fin_num <= w_num_ext[ramr_pkg::NUM_OUT_W-1:0];
                    r_fin_den <= w_den_ext[ramr_pkg::DEN_OUT_W-1:0];
                    r_fin_dz  <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // output valid: set on hand-off, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ramr_pkg::S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload: load on hand-off, hold otherwise
    always_ff @(posedge i_clk) begin
        if ((r_state == ramr_pkg::S_DONE) && w_out_free) begin
            r_out_num <= r_fin_num;
            r_out_den <= r_fin_den;
            r_out_dz  <= r_fin_dz;
        end
    end

    assign o_in_stall  = (r_state != ramr_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_res_num   = r_out_num;
    assign o_res_den   = r_out_den;
    assign o_div_zero  = r_out_dz;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != ramr_pkg::S_IDLE))
        else $error("accepted request did not start work");

    a_gcd_u_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ramr_pkg::S_GCD) |-> (r_u != '0))
        else $error("gcd operand went to zero");

    a_div_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_div_zero) |-> ((o_res_num == '0) && (o_res_den == '0)))
        else $error("zero-denominator result is not 0/0");

endmodule

// File: tb/rational_quotient_checker.sv
// Watch both channels of the rational core, predict every reduced fraction and
// compare each accepted result with the oldest prediction still waiting.
module rational_quotient_checker #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_stall,
    input  logic                                    i_opcode,
    input  logic signed [OPERAND_WIDTH-1:0]         i_num_a,
    input  logic signed [OPERAND_WIDTH-1:0]         i_den_a,
    input  logic signed [OPERAND_WIDTH-1:0]         i_num_b,
    input  logic signed [OPERAND_WIDTH-1:0]         i_den_b,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_stall,
    input  logic signed [ramr_pkg::NUM_OUT_W-1:0]   i_res_num,
    input  logic signed [ramr_pkg::DEN_OUT_W-1:0]   i_res_den,
    input  logic                                    i_div_zero,
    output int                                      o_pending,
    output int                                      o_mismatches,
    output int                                      o_checked
);

    typedef struct packed {
        logic signed [ramr_pkg::NUM_OUT_W-1:0] num;
        logic signed [ramr_pkg::DEN_OUT_W-1:0] den;
        logic                                  div_zero;
    } t_quotient;

    t_quotient quotients_due[$];
    int        mismatch_count = 0;
    int        checked_count  = 0;

    // Form the sum or product, then divide both parts by the gcd of their magnitudes
    function automatic t_quotient reduce_fraction(
        input logic                            op,
        input logic signed [OPERAND_WIDTH-1:0] na,
        input logic signed [OPERAND_WIDTH-1:0] da,
        input logic signed [OPERAND_WIDTH-1:0] nb,
        input logic signed [OPERAND_WIDTH-1:0] db
    );
        t_quotient q;
        longint    num;
        longint    den;
        longint    mag_n;
        longint    mag_d;
        longint    rem;
        longint    part;
        q = '0;
        // A zero denominator on either side gives 0/0 with the flag set
        if (da == 0 || db == 0) begin
            q.div_zero = 1'b1;
            return q;
        end
        den = longint'(da) * longint'(db);
        if (op == ramr_pkg::OP_MUL) begin
            num = longint'(na) * longint'(nb);
        end else begin
            num = longint'(na) * longint'(db) + longint'(nb) * longint'(da);
        end
        // A zero numerator always comes out as 0/1
        if (num == 0) begin
            q.den = 1;
            return q;
        end
        mag_n = (num < 0) ? -num : num;
        mag_d = (den < 0) ? -den : den;
        while (mag_d != 0) begin
            rem   = mag_n % mag_d;
            mag_n = mag_d;
            mag_d = rem;
        end
        // Exact division keeps the signs that the products gave
        part  = num / mag_n;
        q.num = part[ramr_pkg::NUM_OUT_W-1:0];
        part  = den / mag_n;
        q.den = part[ramr_pkg::DEN_OUT_W-1:0];
        return q;
    endfunction

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", checked_count, msg);
        mismatch_count++;
    endtask

    // Queue a prediction per accepted request, check each accepted result
    always @(posedge i_clk) begin : watch
        t_quotient want;
        if (!i_rst_n) begin
            quotients_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                quotients_due.push_back(reduce_fraction(i_opcode, i_num_a, i_den_a,
                                                        i_num_b, i_den_b));
            end
            if (i_out_valid && !i_out_stall) begin
                if (quotients_due.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = quotients_due.pop_front();
                    if (i_res_num !== want.num) begin
                        report_mismatch($sformatf("res_num %0d, expected %0d",
                                                  i_res_num, want.num));
                    end
                    if (i_res_den !== want.den) begin
                        report_mismatch($sformatf("res_den %0d, expected %0d",
                                                  i_res_den, want.den));
                    end
                    if (i_div_zero !== want.div_zero) begin
                        report_mismatch($sformatf("div_zero %b, expected %b",
                                                  i_div_zero, want.div_zero));
                    end
                end
                checked_count++;
            end
        end
        o_pending    <= quotients_due.size();
        o_mismatches <= mismatch_count;
        o_checked    <= checked_count;
    end

endmodule

// File: tb/testbench.sv
module testbench;

    localparam int     OPERAND_WIDTH    = 16;
    localparam int     HALF_PERIOD      = 6;
    localparam int     RESET_CYCLES     = 10;
    localparam int     MAX_WAIT         = 17;
    localparam int     LONG_HOLD_CYCLES = 2500;
    localparam int     BURST_ITEMS      = 12;
    localparam int     DRAIN_LIMIT      = 20000;
    localparam int     SETTLE_CYCLES    = 300;
    localparam longint RUN_LIMIT        = 64'd1_500_000 * 2 * HALF_PERIOD;

    logic                                    i_clk      = 1'b0;
    logic                                    i_rst_n    = 1'b0;
    logic                                    i_in_valid = 1'b0;
    logic                                    i_opcode   = ramr_pkg::OP_ADD;
    logic signed [OPERAND_WIDTH-1:0]         i_num_a    = '0;
    logic signed [OPERAND_WIDTH-1:0]         i_den_a    = '0;
    logic signed [OPERAND_WIDTH-1:0]         i_num_b    = '0;
    logic signed [OPERAND_WIDTH-1:0]         i_den_b    = '0;
    logic                                    i_out_stall = 1'b0;
    logic                                    o_in_stall;
    logic                                    o_out_valid;
    logic signed [ramr_pkg::NUM_OUT_W-1:0]   o_res_num;
    logic signed [ramr_pkg::DEN_OUT_W-1:0]   o_res_den;
    logic                                    o_div_zero;

    int pending;
    int mismatches;
    int checked;

    int tx_gap_max   = MAX_WAIT;
    int rx_gap_max   = MAX_WAIT;
    bit rx_long_hold = 1'b0;
    int add_count    = 0;
    int mul_count    = 0;
    int zero_den_count = 0;

    rational_add_mul_reduce_core #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_num_a    (i_num_a),
        .i_den_a    (i_den_a),
        .i_num_b    (i_num_b),
        .i_den_b    (i_den_b),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_div_zero (o_div_zero)
    );

    rational_quotient_checker #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) quotient_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_num_a     (i_num_a),
        .i_den_a     (i_den_a),
        .i_num_b     (i_num_b),
        .i_den_b     (i_den_b),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_res_num   (o_res_num),
        .i_res_den   (o_res_den),
        .i_div_zero  (o_div_zero),
        .o_pending   (pending),
        .o_mismatches(mismatches),
        .o_checked   (checked)
    );

    // Toggle the clock
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Idle a random number of cycles, then offer one request and hold it until taken
    task automatic send_request(
        input logic                            op,
        input logic signed [OPERAND_WIDTH-1:0] na,
        input logic signed [OPERAND_WIDTH-1:0] da,
        input logic signed [OPERAND_WIDTH-1:0] nb,
        input logic signed [OPERAND_WIDTH-1:0] db
    );
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_num_a    <= na;
        i_den_a    <= da;
        i_num_b    <= nb;
        i_den_b    <= db;
        do @(posedge i_clk); while (o_in_stall);
        if (da == 0 || db == 0) zero_den_count++;
        if (op == ramr_pkg::OP_MUL) mul_count++;
        else add_count++;
    endtask

    // Draw one fraction part: a zero denominator, full range, small values, extremes or powers of two
    function automatic logic signed [OPERAND_WIDTH-1:0] pick_part(input bit is_den);
        int sel;
        logic signed [OPERAND_WIDTH-1:0] v;
        sel = $urandom_range(0, 99);
        if (is_den && sel < 4) begin
            v = '0;
        end else if (sel < 45) begin
            v = OPERAND_WIDTH'($urandom);
        end else if (sel < 75) begin
            v = OPERAND_WIDTH'($urandom_range(0, 40) - 20);
        end else if (sel < 90) begin
            case ($urandom_range(0, 5))
                0: v = -32768;
                1: v = -32767;
                2: v = -1;
                3: v = 1;
                4: v = 32766;
                default: v = 32767;
            endcase
        end else begin
            v = OPERAND_WIDTH'(1 << $urandom_range(0, OPERAND_WIDTH - 2));
            if ($urandom_range(0, 1)) v = -v;
        end
        return v;
    endfunction

    // Send one random request
    task automatic send_random();
        send_request($urandom_range(0, 1) ? ramr_pkg::OP_MUL : ramr_pkg::OP_ADD,
                     pick_part(1'b0), pick_part(1'b1), pick_part(1'b0), pick_part(1'b1));
    endtask

    // Stall each result a random number of cycles once it shows; hold off long on request
    initial begin : receiver
        int n;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_long_hold) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                rx_long_hold = 1'b0;
            end
            n = $urandom_range(0, rx_gap_max);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                do @(posedge i_clk); while (!o_out_valid);
                repeat (n - 1) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // End the run if it hangs
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("timeout after %0d time units", RUN_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        int drain_cycles;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: plain cases, extremes, negative and zero denominators, zero sums
        send_request(ramr_pkg::OP_ADD, 1, 2, 1, 3);
        send_request(ramr_pkg::OP_MUL, 2, 3, 3, 4);
        send_request(ramr_pkg::OP_ADD, -32768, -32768, -32768, -32768);
        send_request(ramr_pkg::OP_MUL, -32768, -32768, -32768, -32768);
        send_request(ramr_pkg::OP_MUL, 32767, 32766, 32767, 32765);
        send_request(ramr_pkg::OP_ADD, 32767, -32768, 32767, 32767);
        send_request(ramr_pkg::OP_ADD, -32768, 1, -32768, 1);
        send_request(ramr_pkg::OP_MUL, -32768, 1, -32768, 1);
        send_request(ramr_pkg::OP_MUL, 32767, 1, 32767, 1);
        send_request(ramr_pkg::OP_ADD, 32767, 32767, -32768, -32768);
        send_request(ramr_pkg::OP_ADD, 1, -2, 1, 3);
        send_request(ramr_pkg::OP_MUL, -1, -1, -1, -1);
        send_request(ramr_pkg::OP_ADD, 12, 18, -20, 30);
        send_request(ramr_pkg::OP_ADD, 1, 1, 1, 1);
        send_request(ramr_pkg::OP_ADD, 3, 0, 1, 2);
        send_request(ramr_pkg::OP_MUL, 1, 2, 5, 0);
        send_request(ramr_pkg::OP_ADD, 0, 0, 0, 0);
        send_request(ramr_pkg::OP_MUL, 7, 0, -32768, 0);
        send_request(ramr_pkg::OP_MUL, 0, 5, 3, 7);
        send_request(ramr_pkg::OP_ADD, 1, 2, -1, 2);
        send_request(ramr_pkg::OP_ADD, 0, -3, 0, 9);
        send_request(ramr_pkg::OP_MUL, 0, -32768, 0, 32767);

        // Random with idling on both sides
        repeat (600) send_random();

        // Random back to back with no idling
        tx_gap_max = 0;
        rx_gap_max = 0;
        repeat (300) send_random();

        // Hold off the receiver while requests keep coming, then let it all drain
        rx_gap_max   = MAX_WAIT;
        rx_long_hold = 1'b1;
        repeat (BURST_ITEMS) send_random();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        // Random with idling again
        tx_gap_max = MAX_WAIT;
        repeat (600) send_random();
        i_in_valid <= 1'b0;

        // Drain the outstanding results, then watch for strays
        drain_cycles = 0;
        do begin
            @(posedge i_clk);
            drain_cycles++;
        end while (pending != 0 && drain_cycles < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d add, %0d multiply, %0d with a zero denominator",
                 add_count + mul_count, add_count, mul_count, zero_den_count);
        $display("checked %0d results, one receiver hold-off of %0d cycles, %0d mismatches",
                 checked, LONG_HOLD_CYCLES, mismatches);
        if (pending != 0) $display("missing results: %0d", pending);
        if (mismatches == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
